// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty bodies under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

// ===== rtl/core/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// Types and constants shared by the sparse fiber statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

    localparam int STAT_W     = 32;
    localparam int SUM_W      = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS = 1'b1;

    localparam logic [1:0] MODE_RESET = 2'd0;
    localparam logic [2:0] DIMS_RESET = 3'd4;

    localparam logic KIND_FIBER   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        DIV_FIBER   = 2'd0,
        DIV_AVG_BW  = 2'd1,
        DIV_AVG_DEN = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     latch;
        logic     div_start;
        div_sel_t div_sel;
        logic     close_fiber;
        logic     close_last;
        logic     update;
        logic     save_abw;
        logic     put_summary;
    } sfs_cmd_t;

    typedef struct packed {
        logic split;
        logic final_flag;
        logic div_done;
        logic out_free;
    } sfs_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/sparse_fiber_stats.sv =====
// ----------------------------------------------------------------------------
// sparse_fiber_stats
// Per-fiber bandwidth and density of a sorted sparse coordinate stream.
// ----------------------------------------------------------------------------
// Takes one coordinate at a time. A request that closes no fiber passes only
// through the compare and update steps. Closing a fiber adds a division:
// a 32-step restoring divider computes the density, one quotient bit per cycle,
// and the result is then handed to the output register; a density that
// saturates skips the divider steps. The request marked tlast also closes
// its fiber and runs two divisions for the averages, each skipping its steps
// when its quotient saturates. Results wait in an output register, so the next
// request is taken while a result is still pending; each closing step stalls
// only until the output register frees. Configuration is written on the cfg
// channel, which is always ready; write it only while no request is in flight.
`default_nettype none

`include "assert_macros.svh"

module sparse_fiber_stats #(
    parameter int DIMS       = 4,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // coord_0, coord_1, ... coord_(DIMS-1)
    input  wire logic [((DIMS*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // fiber_span, fiber_nonzeros, fiber_fill, mean_span,
    // mean_fill, fiber_total, nonzero_total
    output logic [((COORD_BITS+1+6*sfs_pkg::STAT_W+7)/8)*8-1:0] m_axis_tdata,
    // kind
    output logic                                     m_axis_tuser,
    output logic                                     m_axis_tlast
);
    import sfs_pkg::*;

    localparam int OUT_RAW = COORD_BITS + 1 + 6 * STAT_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    sfs_cmd_t           cmd;
    sfs_stat_t          stat;
    logic [OUT_RAW-1:0] out_data;

    sfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sfs_dp #(
        .DIMS       (DIMS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata[DIMS*COORD_BITS-1:0]),
        .in_last   (s_axis_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast),
        .out_data  (out_data)
    );

    assign m_axis_tdata = OUT_W'(out_data);

    `ASSERT_IMPLY(a_close_free, clk, rst_n, cmd.close_fiber, stat.out_free)
    `ASSERT_IMPLY(a_summary_free, clk, rst_n, cmd.put_summary, stat.out_free)
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

`default_nettype wire

// ===== rtl/core/sfs_div.sv =====
// ----------------------------------------------------------------------------
// sfs_div
// Radix-2 restoring divider: floor(num * 2^16 / den) or floor(num / den),
// saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        shift16,
    input  wire logic [63:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [31:0]      quot
);
    import sfs_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] bits_reg, bits_next;
    logic [31:0] den_reg, den_next;
    logic [95:0] x;
    logic        sat;
    logic [32:0] t;
    logic [32:0] diff;
    logic        ge;

    always_comb
    begin
        x    = shift16 ? {16'b0, num, 16'b0} : {32'b0, num};
        sat  = x[95:32] >= {32'b0, den};
        t    = {rem_reg, bits_reg[31]};
        ge   = t >= {1'b0, den_reg};
        diff = t - {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        bits_next = bits_reg;
        den_next  = den_reg;
        if (start)
        begin
            den_next = den;
            if (sat)
            begin
                bits_next = '1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = x[63:32];
                bits_next = x[31:0];
                cnt_next  = 6'd32;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[31:0] : t[31:0];
            bits_next = {bits_reg[30:0], ge};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = bits_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfs_ctrl
// Sequencer: compare, close, update, and summary steps for each request.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sfs_pkg::sfs_stat_t stat,
    output sfs_pkg::sfs_cmd_t      cmd
);
    import sfs_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_CHECK  = 12'b0000_0000_0010,
        ST_CDIV   = 12'b0000_0000_0100,
        ST_CPUT   = 12'b0000_0000_1000,
        ST_UPD    = 12'b0000_0001_0000,
        ST_FSTART = 12'b0000_0010_0000,
        ST_FDIV   = 12'b0000_0100_0000,
        ST_FPUT   = 12'b0000_1000_0000,
        ST_ASTART = 12'b0001_0000_0000,
        ST_ADIV   = 12'b0010_0000_0000,
        ST_DDIV   = 12'b0100_0000_0000,
        ST_SPUT   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_FIBER;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.split)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_CDIV;
                end
                else
                begin
                    state_next = ST_UPD;
                end
            end
            ST_CDIV:
            begin
                if (stat.div_done)
                    state_next = ST_CPUT;
            end
            ST_CPUT:
            begin
                if (stat.out_free)
                begin
                    cmd.close_fiber = 1'b1;
                    cmd.close_last  = !stat.final_flag;
                    state_next      = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = stat.final_flag ? ST_FSTART : ST_IDLE;
            end
            ST_FSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_FDIV;
            end
            ST_FDIV:
            begin
                if (stat.div_done)
                    state_next = ST_FPUT;
            end
            ST_FPUT:
            begin
                if (stat.out_free)
                begin
                    cmd.close_fiber = 1'b1;
                    state_next      = ST_ASTART;
                end
            end
            ST_ASTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_AVG_BW;
                state_next    = ST_ADIV;
            end
            ST_ADIV:
            begin
                cmd.div_sel = DIV_AVG_DEN;
                if (stat.div_done)
                begin
                    cmd.save_abw  = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DDIV;
                end
            end
            ST_DDIV:
            begin
                if (stat.div_done)
                    state_next = ST_SPUT;
            end
            ST_SPUT:
            begin
                if (stat.out_free)
                begin
                    cmd.put_summary = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sfs_dp.sv =====
// ----------------------------------------------------------------------------
// sfs_dp
// Datapath: configuration, fiber key and bounds, totals, divider, result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_dp #(
    parameter int DIMS       = 4,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [DIMS*COORD_BITS-1:0]          in_data,
    input  wire logic                                in_last,
    input  wire sfs_pkg::sfs_cmd_t                   cmd,
    output sfs_pkg::sfs_stat_t                       stat,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     out_kind,
    output logic                                     out_last,
    output logic [COORD_BITS+1+6*sfs_pkg::STAT_W-1:0] out_data
);
    import sfs_pkg::*;

    localparam int IDX_W = $clog2(DIMS);
    localparam int BW_W  = COORD_BITS + 1;

    logic [1:0]            mode_reg;
    logic [2:0]            dims_reg;
    logic [COORD_BITS-1:0] coord_reg [DIMS];
    logic                  final_reg;
    logic [COORD_BITS-1:0] key_reg [DIMS];
    logic [COORD_BITS-1:0] key_next [DIMS];
    logic                  open_reg, open_next;
    logic [COORD_BITS-1:0] low_reg, low_next;
    logic [COORD_BITS-1:0] high_reg, high_next;
    logic [STAT_W-1:0]     cnt_reg, cnt_next;
    logic [STAT_W-1:0]     fibers_reg, fibers_next;
    logic [STAT_W-1:0]     nz_reg, nz_next;
    logic [SUM_W-1:0]      bw_sum_reg, bw_sum_next;
    logic [SUM_W-1:0]      den_sum_reg, den_sum_next;
    logic [STAT_W-1:0]     abw_reg;

    logic                  ov_reg, ov_next;
    logic                  ok_reg, ol_reg;
    logic [BW_W-1:0]       o_bw_reg;
    logic [STAT_W-1:0]     o_nz_reg, o_den_reg, o_abw_reg, o_aden_reg, o_ft_reg, o_nt_reg;

    logic [IDX_W-1:0]      m_idx;
    logic                  differ;
    logic [COORD_BITS-1:0] v;
    logic [BW_W-1:0]       bw;
    logic [SUM_W:0]        bw_add, den_add;
    logic [SUM_W-1:0]      div_num;
    logic [STAT_W-1:0]     div_den;
    logic                  div_shift;
    logic                  div_done;
    logic [STAT_W-1:0]     quot;
    logic                  out_free;

    sfs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .shift16 (div_shift),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (quot)
    );

    always_comb
    begin
        m_idx  = (int'(mode_reg) < DIMS) ? IDX_W'(mode_reg) : '0;
        differ = 1'b0;
        for (int i = 0; i < DIMS; i++)
        begin
            if (i < int'(dims_reg) && i != int'(m_idx) && coord_reg[i] != key_reg[i])
                differ = 1'b1;
        end
        v       = coord_reg[m_idx];
        bw      = {1'b0, high_reg} - {1'b0, low_reg} + BW_W'(1);
        bw_add  = {1'b0, bw_sum_reg} + (SUM_W + 1)'(bw);
        den_add = {1'b0, den_sum_reg} + (SUM_W + 1)'(quot);
        out_free = !ov_reg || out_ready;

        case (cmd.div_sel)
            DIV_AVG_BW:
            begin
                div_num   = bw_sum_reg;
                div_den   = (fibers_reg == '0) ? STAT_W'(1) : fibers_reg;
                div_shift = 1'b1;
            end
            DIV_AVG_DEN:
            begin
                div_num   = den_sum_reg;
                div_den   = (fibers_reg == '0) ? STAT_W'(1) : fibers_reg;
                div_shift = 1'b0;
            end
            default:
            begin
                div_num   = SUM_W'(bw);
                div_den   = (cnt_reg == '0) ? STAT_W'(1) : cnt_reg;
                div_shift = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        key_next     = key_reg;
        open_next    = open_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        cnt_next     = cnt_reg;
        fibers_next  = fibers_reg;
        nz_next      = nz_reg;
        bw_sum_next  = bw_sum_reg;
        den_sum_next = den_sum_reg;
        ov_next      = ov_reg && !out_ready;

        if (cmd.close_fiber)
        begin
            bw_sum_next  = bw_add[SUM_W] ? '1 : bw_add[SUM_W-1:0];
            den_sum_next = den_add[SUM_W] ? '1 : den_add[SUM_W-1:0];
            fibers_next  = (fibers_reg == '1) ? fibers_reg : fibers_reg + STAT_W'(1);
            open_next    = 1'b0;
            ov_next      = 1'b1;
        end
        if (cmd.update)
        begin
            if (!open_reg)
            begin
                key_next  = coord_reg;
                low_next  = v;
                high_next = v;
                cnt_next  = STAT_W'(1);
                open_next = 1'b1;
            end
            else
            begin
                if (v < low_reg)
                    low_next = v;
                if (v > high_reg)
                    high_next = v;
                cnt_next = (cnt_reg == '1) ? cnt_reg : cnt_reg + STAT_W'(1);
            end
            nz_next = (nz_reg == '1) ? nz_reg : nz_reg + STAT_W'(1);
        end
        if (cmd.put_summary)
        begin
            for (int i = 0; i < DIMS; i++)
                key_next[i] = '0;
            open_next    = 1'b0;
            low_next     = '1;
            high_next    = '0;
            cnt_next     = '0;
            fibers_next  = '0;
            nz_next      = '0;
            bw_sum_next  = '0;
            den_sum_next = '0;
            ov_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RESET;
            dims_reg    <= DIMS_RESET;
            for (int i = 0; i < DIMS; i++)
                key_reg[i] <= '0;
            open_reg    <= 1'b0;
            low_reg     <= '1;
            high_reg    <= '0;
            cnt_reg     <= '0;
            fibers_reg  <= '0;
            nz_reg      <= '0;
            bw_sum_reg  <= '0;
            den_sum_reg <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MODE: mode_reg <= cfg_data[1:0];
                    REG_DIMS: dims_reg <= cfg_data;
                    default:  ;
                endcase
            end
            key_reg     <= key_next;
            open_reg    <= open_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            cnt_reg     <= cnt_next;
            fibers_reg  <= fibers_next;
            nz_reg      <= nz_next;
            bw_sum_reg  <= bw_sum_next;
            den_sum_reg <= den_sum_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            for (int i = 0; i < DIMS; i++)
                coord_reg[i] <= in_data[i*COORD_BITS +: COORD_BITS];
            final_reg <= in_last;
        end
        if (cmd.save_abw)
            abw_reg <= quot;
        if (cmd.close_fiber)
        begin
            ok_reg     <= KIND_FIBER;
            ol_reg     <= cmd.close_last;
            o_bw_reg   <= bw;
            o_nz_reg   <= cnt_reg;
            o_den_reg  <= quot;
            o_abw_reg  <= '0;
            o_aden_reg <= '0;
            o_ft_reg   <= '0;
            o_nt_reg   <= '0;
        end
        if (cmd.put_summary)
        begin
            ok_reg     <= KIND_SUMMARY;
            ol_reg     <= 1'b1;
            o_bw_reg   <= '0;
            o_nz_reg   <= '0;
            o_den_reg  <= '0;
            o_abw_reg  <= abw_reg;
            o_aden_reg <= quot;
            o_ft_reg   <= fibers_reg;
            o_nt_reg   <= nz_reg;
        end
    end

    assign cfg_ready       = 1'b1;
    assign stat.split      = open_reg && differ;
    assign stat.final_flag = final_reg;
    assign stat.div_done   = div_done;
    assign stat.out_free   = out_free;
    assign out_valid       = ov_reg;
    assign out_kind        = ok_reg;
    assign out_last        = ol_reg;
    assign out_data        = {o_nt_reg, o_ft_reg, o_aden_reg, o_abw_reg,
                              o_den_reg, o_nz_reg, o_bw_reg};

endmodule

`default_nettype wire
